>>> src/mms_pkg.sv
// Shared types and constants for the markup math segmenter.
package mms_pkg;

    // Internal offset arithmetic width; offsets wrap modulo 2**OFS_W
    localparam int OFS_W   = 16;
    // Width of the start and length result fields
    localparam int FIELD_W = 16;
    localparam int KIND_W  = 3;

    // Result queue geometry
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = QPTR_W + 1;

    // Segment kinds
    localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INLINE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISPLAY = 3'd2;
    localparam logic [KIND_W-1:0] KIND_LINEBRK = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PARBRK  = 3'd4;

    // Markup characters
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_BSL    = 8'h5C;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               run_end;
        logic               doc_done;
    } t_result;

    // Up to two results caused by one byte, packed toward slot 0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_result_pair;

endpackage

>>> src/markup_math_segmenter_unit.sv
// Top level of the markup math segmenter: byte scanner feeding a result queue.
//
//  channel  direction  handshake               payload
//  in       sink       i_in_valid/o_in_ready   i_char_byte, i_final_byte
//  out      source     o_out_valid/i_out_ready o_segment_kind, o_segment_start,
//                                              o_segment_length, o_run_end,
//                                              o_document_done
//
// One byte is scanned in the cycle it transfers; its results are in the queue
// the next cycle and reach the output behind older ones. A byte is taken every cycle while
// the four-entry result queue holds at most two results, so output stalls or
// bytes giving two results throttle input. Reset (synchronous, active low)
// returns to plain text at offset zero and empties the queue.
module markup_math_segmenter_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_char_byte,
    input  logic                         i_final_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [mms_pkg::KIND_W-1:0]   o_segment_kind,
    output logic [mms_pkg::FIELD_W-1:0]  o_segment_start,
    output logic [mms_pkg::FIELD_W-1:0]  o_segment_length,
    output logic                         o_run_end,
    output logic                         o_document_done
);

    logic                  accept;
    logic                  space2;
    mms_pkg::t_result_pair pair;
    mms_pkg::t_result      head;

    assign o_in_ready = space2;
    assign accept     = i_in_valid && space2;

    mms_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char_byte  (i_char_byte),
        .i_final_byte (i_final_byte),
        .o_res        (pair)
    );

    mms_res_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_pair   (pair),
        .i_pop    (o_out_valid && i_out_ready),
        .o_space2 (space2),
        .o_valid  (o_out_valid),
        .o_data   (head)
    );

    assign o_segment_kind   = head.kind;
    assign o_segment_start  = head.start;
    assign o_segment_length = head.length;
    assign o_run_end        = head.run_end;
    assign o_document_done  = head.doc_done;

endmodule

>>> src/mms_scan.sv
// Byte scanner: mode state, offsets and the results decided by each byte.
module mms_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_char_byte,
    input  logic                  i_final_byte,
    output mms_pkg::t_result_pair o_res
);

    localparam int W  = mms_pkg::OFS_W;
    localparam int FW = mms_pkg::FIELD_W;

    typedef enum logic [2:0] {
        M_TEXT = 3'd0,
        M_BSL  = 3'd1,
        M_NL   = 3'd2,
        M_INL  = 3'd3,
        M_DD   = 3'd4,
        M_DDP  = 3'd5,
        M_BD   = 3'd6,
        M_BDP  = 3'd7
    } t_mode;

    t_mode          r_mode, n_mode;
    logic [W-1:0]   r_pos, n_pos;
    logic [W-1:0]   r_origin, n_origin;
    logic [W-1:0]   r_nlpos, n_nlpos;

    logic [W-1:0]   p, nx, prev;
    logic           text_byte;
    logic           a_req, a_valid;
    logic [W-1:0]   a_end, a_len;
    logic           b_valid;
    logic [mms_pkg::KIND_W-1:0] b_kind;
    logic [W-1:0]   b_start, b_len;
    logic           f_valid;
    logic [mms_pkg::KIND_W-1:0] f_kind;
    logic [W-1:0]   f_len;
    mms_pkg::t_result res_a, res_b, res_f;
    mms_pkg::t_result_pair pair;

    always_comb begin
        p    = r_pos;
        nx   = r_pos + W'(1);
        prev = r_pos - W'(1);

        n_mode    = r_mode;
        n_origin  = r_origin;
        n_nlpos   = r_nlpos;
        text_byte = 1'b0;
        a_req     = 1'b0;
        a_end     = p;
        b_valid   = 1'b0;
        b_kind    = mms_pkg::KIND_TEXT;
        b_start   = r_origin;
        b_len     = '0;

        case (r_mode)
            M_BSL: begin
                if (i_char_byte == mms_pkg::CH_LBRK) begin
                    a_req    = 1'b1;
                    a_end    = prev;
                    n_mode   = M_BD;
                    n_origin = nx;
                end else if (i_char_byte == mms_pkg::CH_BSL) begin
                    a_req    = 1'b1;
                    a_end    = prev;
                    b_valid  = 1'b1;
                    b_kind   = mms_pkg::KIND_LINEBRK;
                    b_start  = '0;
                    n_mode   = M_TEXT;
                    n_origin = nx;
                end else begin
                    n_mode    = M_TEXT;
                    text_byte = 1'b1;
                end
            end
            M_NL: begin
                if (i_char_byte == mms_pkg::CH_SPACE || i_char_byte == mms_pkg::CH_TAB) begin
                    n_mode = M_NL;
                end else if (i_char_byte == mms_pkg::CH_NL) begin
                    a_req    = 1'b1;
                    a_end    = r_nlpos;
                    b_valid  = 1'b1;
                    b_kind   = mms_pkg::KIND_PARBRK;
                    b_start  = '0;
                    n_mode   = M_TEXT;
                    n_origin = nx;
                end else begin
                    n_mode    = M_TEXT;
                    text_byte = 1'b1;
                end
            end
            M_INL: begin
                if (i_char_byte == mms_pkg::CH_DOLLAR) begin
                    // a dollar right after the opener turns it into display math
                    if (p == r_origin) begin
                        n_mode = M_DD;
                    end else begin
                        b_valid = 1'b1;
                        b_kind  = mms_pkg::KIND_INLINE;
                        b_len   = p - r_origin;
                        n_mode  = M_TEXT;
                    end
                    n_origin = nx;
                end
            end
            M_DD: begin
                if (i_char_byte == mms_pkg::CH_DOLLAR) begin
                    n_mode = M_DDP;
                end
            end
            M_DDP: begin
                if (i_char_byte == mms_pkg::CH_DOLLAR) begin
                    b_valid  = 1'b1;
                    b_kind   = mms_pkg::KIND_DISPLAY;
                    b_len    = prev - r_origin;
                    n_mode   = M_TEXT;
                    n_origin = nx;
                end else begin
                    n_mode = M_DD;
                end
            end
            M_BD: begin
                if (i_char_byte == mms_pkg::CH_BSL) begin
                    n_mode = M_BDP;
                end
            end
            M_BDP: begin
                if (i_char_byte == mms_pkg::CH_RBRK) begin
                    b_valid  = 1'b1;
                    b_kind   = mms_pkg::KIND_DISPLAY;
                    b_len    = prev - r_origin;
                    n_mode   = M_TEXT;
                    n_origin = nx;
                end else if (i_char_byte != mms_pkg::CH_BSL) begin
                    n_mode = M_BD;
                end
            end
            default: begin
                text_byte = 1'b1;
            end
        endcase

        if (text_byte) begin
            if (i_char_byte == mms_pkg::CH_DOLLAR) begin
                a_req    = 1'b1;
                a_end    = p;
                n_mode   = M_INL;
                n_origin = nx;
            end else if (i_char_byte == mms_pkg::CH_BSL) begin
                n_mode = M_BSL;
            end else if (i_char_byte == mms_pkg::CH_NL) begin
                n_mode  = M_NL;
                n_nlpos = p;
            end
        end

        a_len   = a_end - r_origin;
        a_valid = a_req && (a_len != '0);

        // End of document closes whatever segment is open
        f_len = nx - n_origin;
        if (n_mode == M_TEXT || n_mode == M_BSL || n_mode == M_NL) begin
            f_kind  = mms_pkg::KIND_TEXT;
            f_valid = i_final_byte && (f_len != '0);
        end else if (n_mode == M_INL) begin
            f_kind  = mms_pkg::KIND_INLINE;
            f_valid = i_final_byte;
        end else begin
            f_kind  = mms_pkg::KIND_DISPLAY;
            f_valid = i_final_byte;
        end

        res_a = '{kind: mms_pkg::KIND_TEXT, start: FW'(r_origin), length: FW'(a_len),
                  run_end: 1'b0, doc_done: 1'b0};
        res_b = '{kind: b_kind, start: FW'(b_start), length: FW'(b_len),
                  run_end: 1'b0, doc_done: 1'b0};
        res_f = '{kind: f_kind, start: FW'(n_origin), length: FW'(f_len),
                  run_end: 1'b0, doc_done: 1'b0};

        pair    = '0;
        pair.r0 = res_f;
        pair.r1 = res_f;
        if (a_valid) begin
            pair.v0 = 1'b1;
            pair.r0 = res_a;
            pair.v1 = b_valid || f_valid;
            pair.r1 = b_valid ? res_b : res_f;
        end else if (b_valid) begin
            pair.v0 = 1'b1;
            pair.r0 = res_b;
            pair.v1 = f_valid;
        end else begin
            pair.v0 = f_valid;
        end
        if (pair.v1) begin
            pair.r1.run_end  = 1'b1;
            pair.r1.doc_done = i_final_byte;
        end else begin
            pair.r0.run_end  = 1'b1;
            pair.r0.doc_done = i_final_byte;
        end

        if (i_final_byte) begin
            n_pos    = '0;
            n_mode   = M_TEXT;
            n_origin = '0;
            n_nlpos  = '0;
        end else begin
            n_pos = nx;
        end
    end

    assign o_res = pair;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_TEXT;
            r_pos    <= '0;
            r_origin <= '0;
            r_nlpos  <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_origin <= n_origin;
            r_nlpos  <= n_nlpos;
        end
    end

`ifndef SYNTHESIS
    a_pair_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_res.v1 |-> o_res.v0)
        else $error("second result without first");

    a_run_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && o_res.v1 |-> o_res.r1.run_end && !o_res.r0.run_end)
        else $error("run_end not on last result");

    a_doc_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_final_byte |=> r_pos == '0 && r_origin == '0 && r_mode == M_TEXT)
        else $error("state not cleared after final byte");

    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && !i_final_byte |=> r_pos == $past(r_pos) + W'(1))
        else $error("byte position did not advance");
`endif

endmodule

>>> src/mms_res_queue.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
module mms_res_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mms_pkg::t_result_pair i_pair,
    input  logic                  i_pop,
    output logic                  o_space2,
    output logic                  o_valid,
    output mms_pkg::t_result      o_data
);

    localparam int PW = mms_pkg::QPTR_W;
    localparam int CW = mms_pkg::QCNT_W;

    mms_pkg::t_result r_mem [mms_pkg::QDEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    push_n;
    logic [PW-1:0]    wr1;

    always_comb begin
        push_n  = i_push ? (CW'(i_pair.v0) + CW'(i_pair.v1)) : '0;
        wr1     = r_wr + PW'(1);
        n_wr    = r_wr + PW'(push_n);
        n_rd    = i_pop ? r_rd + PW'(1) : r_rd;
        n_count = r_count + push_n - CW'(i_pop);
    end

    assign o_space2 = r_count <= CW'(mms_pkg::QDEPTH - 2);
    assign o_valid  = r_count != '0;
    assign o_data   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push && i_pair.v0) begin
            r_mem[r_wr] <= i_pair.r0;
        end
        if (i_push && i_pair.v1) begin
            r_mem[wr1] <= i_pair.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(mms_pkg::QDEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space2)
        else $error("push without room for two results");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
`endif

endmodule
